### rtl/core/skbi_pkg.sv
// Package for the sorted key bucket insert block: sizes, word types and the
// command and status groups between controller and datapath. No dependencies.
`default_nettype none

package skbi_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int MAX_ITEMS = 4096;

  localparam int KEY_W  = 64;
  localparam int POS_W  = 13;
  localparam int SLOT_W = 6;
  localparam int ADDR_W = $clog2(MAX_KEYS);
  localparam int ENT_W  = $clog2(MAX_KEYS + 1);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SUBMIT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] material_key;
  } skbi_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  draw_position;
    logic [SLOT_W-1:0] material_slot;
    logic              new_material;
    logic              overflow;
  } skbi_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } skbi_entry_t;

  localparam int ENTRY_W = $bits(skbi_entry_t);

  typedef struct packed {
    logic load;
    logic seed;
    logic srch_rd;
    logic srch_step;
    logic hit;
    logic sh_init;
    logic sh_rd;
    logic sh_wr;
    logic bump;
    logic insert;
    logic ovf;
    logic out_load;
  } skbi_cmd_t;

  typedef struct packed {
    logic func;
    logic srch_end;
    logic key_eq;
    logic key_gt;
    logic equal;
    logic full;
    logic sh_done;
  } skbi_sts_t;

endpackage

`default_nettype wire

### rtl/core/skbi_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module skbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/skbi_datapath.sv
// Datapath of the sorted key bucket insert block: the entry RAM, totals,
// search and shift pointers and the result register. Depends on skbi_pkg, skbi_ram.
`default_nettype none

module skbi_datapath
  import skbi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire skbi_in_t  in_data,
  input  wire skbi_cmd_t cmd,
  output skbi_sts_t      sts,
  output skbi_out_t      out_data
);

  logic [KEY_W-1:0] key_r;
  logic             func_r;
  logic [ENT_W-1:0] idx_r;
  logic [ENT_W-1:0] sh_r;
  logic [CNT_W-1:0] prefix_r;
  logic [CNT_W-1:0] cnt_r;
  logic             equal_r;
  logic [ENT_W-1:0] entry_total_r, entry_total_nxt;
  logic [CNT_W-1:0] item_total_r, item_total_nxt;
  skbi_out_t        res_r;
  skbi_out_t        out_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  skbi_entry_t       wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  skbi_entry_t       rdata;
  logic [ENT_W-1:0]  sh_prev;

  assign sh_prev = sh_r - ENT_W'(1);

  skbi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[ADDR_W-1:0];
    wdata = '{key: key_r, count: CNT_W'(1)};
    if (cmd.seed) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '{key: key_r, count: '0};
    end else if (cmd.sh_wr) begin
      we    = 1'b1;
      waddr = sh_r[ADDR_W-1:0];
      wdata = rdata;
    end else if (cmd.bump) begin
      we    = 1'b1;
      wdata = '{key: key_r, count: cnt_r + CNT_W'(1)};
    end else if (cmd.insert) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    re    = cmd.srch_rd | cmd.sh_rd;
    raddr = cmd.sh_rd ? sh_prev[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  end

  always_comb begin
    entry_total_nxt = entry_total_r;
    item_total_nxt  = item_total_r;
    if (cmd.seed) begin
      entry_total_nxt = ENT_W'(1);
      item_total_nxt  = '0;
    end else if (cmd.bump) begin
      item_total_nxt  = item_total_r + CNT_W'(1);
    end else if (cmd.insert) begin
      entry_total_nxt = entry_total_r + ENT_W'(1);
      item_total_nxt  = item_total_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_total_r <= '0;
      item_total_r  <= '0;
    end else begin
      entry_total_r <= entry_total_nxt;
      item_total_r  <= item_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_data.material_key;
      func_r   <= in_data.func;
      idx_r    <= '0;
      prefix_r <= '0;
      equal_r  <= 1'b0;
    end
    if (cmd.hit) begin
      equal_r <= 1'b1;
      cnt_r   <= rdata.count;
    end
    if (cmd.srch_step) begin
      prefix_r <= prefix_r + rdata.count;
      idx_r    <= idx_r + ENT_W'(1);
    end
    if (cmd.sh_init) begin
      sh_r <= entry_total_r;
    end
    if (cmd.sh_wr) begin
      sh_r <= sh_prev;
    end
    if (cmd.seed) begin
      res_r <= '{draw_position: '0, material_slot: '0, new_material: 1'b1, overflow: 1'b0};
    end
    if (cmd.ovf) begin
      res_r <= '{draw_position: '0, material_slot: '0, new_material: 1'b0, overflow: 1'b1};
    end
    if (cmd.bump || cmd.insert) begin
      res_r <= '{draw_position: prefix_r, material_slot: idx_r[SLOT_W-1:0],
                 new_material: cmd.insert, overflow: 1'b0};
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign sts.func     = func_r;
  assign sts.srch_end = (idx_r == entry_total_r);
  assign sts.key_eq   = (rdata.key == key_r);
  assign sts.key_gt   = (rdata.key > key_r);
  assign sts.equal    = equal_r;
  assign sts.full     = (item_total_r >= CNT_W'(MAX_ITEMS)) ||
                        (!equal_r && (entry_total_r >= ENT_W'(MAX_KEYS)));
  assign sts.sh_done  = (sh_r == idx_r);
  assign out_data     = out_r;

endmodule

`default_nettype wire

### rtl/core/skbi_ctrl.sv
// Controller of the sorted key bucket insert block: sequences search, shift
// and write-back, and owns the handshakes. Depends on skbi_pkg.
`default_nettype none

module skbi_ctrl
  import skbi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire skbi_sts_t sts,
  output skbi_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_SRD, S_SCMP, S_DECIDE, S_SHRD, S_SHWR, S_INS, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        if (sts.func == FUNC_START) begin
          cmd.seed  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.srch_end) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.key_eq) begin
          cmd.hit   = 1'b1;
          state_nxt = S_DECIDE;
        end else if (sts.key_gt) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.srch_step = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_DECIDE: begin
        if (sts.full) begin
          cmd.ovf   = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.equal) begin
          cmd.bump  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.sh_init = 1'b1;
          state_nxt   = S_SHRD;
        end
      end
      S_SHRD: begin
        if (sts.sh_done) begin
          state_nxt = S_INS;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/core/sorted_key_bucket_insert.sv
// Top level of the sorted key bucket insert block: controller and datapath.
// Depends on skbi_pkg, skbi_ctrl, skbi_datapath.
//
// Usage: each input word carries func and material_key. A start word clears
// the table and seeds it with its key at a count of zero. A submit word
// searches the ascending key table, then counts, inserts or appends the key,
// and returns its draw position, table slot, new flag and overflow flag.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. One result word is returned for every input word.
// Timing: a start passes through the load, seed and finish states before its
// result is valid. A submit reads and compares one table entry per search
// step, and moves one entry up per shift step on an insertion; both
// loops are set by the single read port of the entry RAM. One word is in
// work at a time: no new input word is taken until the last one has finished.
// Reset empties the table and clears both totals and the output valid. The
// table RAM is not cleared; only entries below the entry total are read.
// A stalled result holds; a finished word waits in the controller until the
// output register is free, and no new input word is taken meanwhile.
`default_nettype none

module sorted_key_bucket_insert
  import skbi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire skbi_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output skbi_out_t     out_data
);

  skbi_cmd_t cmd;
  skbi_sts_t sts;

  skbi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  skbi_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

### rtl/core/skbi_checker.sv
// Port-level checks for sorted_key_bucket_insert and the bind that attaches
// them. Depends on skbi_pkg and sorted_key_bucket_insert.
`default_nettype none

module skbi_checker
  import skbi_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire skbi_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire skbi_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a word is in work");

  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      out_data.draw_position == '0 && out_data.material_slot == '0 &&
      !out_data.new_material)
    else $error("overflow result carries data");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func == FUNC_START && !out_valid |->
      ##3 out_valid && out_data.new_material && !out_data.overflow &&
      out_data.draw_position == '0 && out_data.material_slot == '0)
    else $error("start word did not return its seed result");

endmodule

bind sorted_key_bucket_insert skbi_checker u_skbi_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for sorted_key_bucket_insert: drives start and submit
// words with random gaps and output stalls, predicts each result word.
// Depends on skbi_pkg and the sorted_key_bucket_insert RTL.
`timescale 1ns / 1ps

module testbench;
  import skbi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  skbi_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  skbi_out_t out_data;

  sorted_key_bucket_insert dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  skbi_in_t  pending_words[$];
  skbi_out_t expected_results[$];

  logic [KEY_W-1:0] bucket_keys[MAX_KEYS];
  int unsigned      bucket_counts[MAX_KEYS];
  int unsigned      bucket_used;
  int unsigned      items_placed;

  int  error_count;
  int  idle_cycles;
  bit  in_accepted = 1'b0;
  int  burst_left;
  int  gap_left;
  int  stall_mode;

  function automatic skbi_out_t place_word(skbi_in_t w);
    skbi_out_t   r;
    int unsigned idx;
    int unsigned prefix;
    bit          hit;
    r = '0;
    prefix = 0;
    hit = 1'b0;
    if (w.func == FUNC_START) begin
      bucket_keys[0] = w.material_key;
      bucket_counts[0] = 0;
      bucket_used = 1;
      items_placed = 0;
      r.new_material = 1'b1;
      return r;
    end
    for (idx = 0; idx < bucket_used; idx++) begin
      if (bucket_keys[idx] == w.material_key) begin
        hit = 1'b1;
        break;
      end
      if (bucket_keys[idx] > w.material_key) break;
      prefix += bucket_counts[idx];
    end
    if (items_placed >= MAX_ITEMS || (!hit && bucket_used >= MAX_KEYS)) begin
      r.overflow = 1'b1;
      return r;
    end
    if (hit) begin
      bucket_counts[idx]++;
    end else begin
      for (int j = bucket_used; j > idx; j--) begin
        bucket_keys[j] = bucket_keys[j-1];
        bucket_counts[j] = bucket_counts[j-1];
      end
      bucket_keys[idx] = w.material_key;
      bucket_counts[idx] = 1;
      bucket_used++;
    end
    items_placed++;
    r.draw_position = prefix[POS_W-1:0];
    r.material_slot = idx[SLOT_W-1:0];
    r.new_material = !hit;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_word(logic f, logic [KEY_W-1:0] k);
    skbi_in_t w;
    w.func = f;
    w.material_key = k;
    pending_words.push_back(w);
  endtask

  // Driver: bursts of words separated by random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accepted) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_mode == 0) out_stall <= 1'b0;
      else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  // Monitor: predict on acceptance, compare results in order.
  always @(posedge clk) begin
    skbi_out_t exp_r;
    if (rst_n) begin
      in_accepted <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(place_word(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %p", $realtime, out_data);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, out_data);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_key_bucket_insert verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] pool[16];
    logic [KEY_W-1:0] k;
    int n;
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    bucket_used = 0;
    items_placed = 0;

    // Directed words: submit before start, extremes, insert, append, match.
    queue_word(FUNC_SUBMIT, 64'd500);
    queue_word(FUNC_SUBMIT, 64'd100);
    queue_word(FUNC_SUBMIT, 64'd500);
    queue_word(FUNC_START, '1);
    queue_word(FUNC_SUBMIT, '1);
    queue_word(FUNC_SUBMIT, '0);
    queue_word(FUNC_SUBMIT, 64'h5555_5555_5555_5555);
    queue_word(FUNC_SUBMIT, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_word(FUNC_SUBMIT, '0);
    queue_word(FUNC_SUBMIT, 64'h8000_0000_0000_0000);
    queue_word(FUNC_START, '0);
    queue_word(FUNC_SUBMIT, '0);
    queue_word(FUNC_SUBMIT, 64'd7);
    // Fill the table to its bound; the last loop key, then key 1, overflow.
    queue_word(FUNC_START, 64'd0);
    for (int i = 1; i <= MAX_KEYS; i++) queue_word(FUNC_SUBMIT, 64'(i * 3));
    queue_word(FUNC_SUBMIT, 64'd6);
    queue_word(FUNC_SUBMIT, 64'd1);

    // Random passes: most begin with a start; some keys are from a small pool.
    n = 0;
    while (n < 1170) begin
      for (int i = 0; i < 16; i++) pool[i] = random_key();
      if ($urandom_range(0, 7) != 0) begin
        queue_word(FUNC_START, pool[$urandom_range(0, 15)]);
        n++;
      end
      for (int i = $urandom_range(5, 90); i > 0; i--) begin
        case ($urandom_range(0, 3))
          0: k = random_key();
          1: k = 64'($urandom_range(0, 40));
          default: k = pool[$urandom_range(0, 15)];
        endcase
        queue_word(FUNC_SUBMIT, k);
        n++;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0 && !out_valid) begin
      $display("sorted_key_bucket_insert verification clean");
    end else begin
      $display("sorted_key_bucket_insert verification failed");
    end
    $finish;
  end
endmodule
